[sv/pcs_pkg.sv]
// Package for the pneumatic cylinder sequencer: command, phase, status and
// alarm event codes, configuration register indexes and shared structs.
// Has no dependencies; every other file imports it.
`timescale 1ns / 1ps

package pcs_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int MS_BITS        = 16;
	localparam int CFG_IDX_BITS   = 3;

	typedef enum logic [2:0] {
		CMD_EXTEND        = 3'd0,
		CMD_RETRACT       = 3'd1,
		CMD_FORCE_EXTEND  = 3'd2,
		CMD_FORCE_RETRACT = 3'd3,
		CMD_RESET         = 3'd4,
		CMD_TICK          = 3'd5
	} cmd_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ENABLE        = 3'd0,
		REG_EXT_FITTED    = 3'd1,
		REG_RET_FITTED    = 3'd2,
		REG_EXT_SETTLE    = 3'd3,
		REG_RET_SETTLE    = 3'd4,
		REG_EXT_TIMEOUT   = 3'd5,
		REG_RET_TIMEOUT   = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_WAIT   = 3'b010,
		PH_SETTLE = 3'b100
	} phase_t;

	localparam logic [1:0] ST_BUSY  = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_FAULT = 2'd2;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_CLEARED = 2'd1;
	localparam logic [1:0] EV_RAISED  = 2'd2;

	typedef struct packed {
		logic               enable;
		logic               ext_fitted;
		logic               ret_fitted;
		logic [MS_BITS-1:0] ext_settle;
		logic [MS_BITS-1:0] ret_settle;
		logic [MS_BITS-1:0] ext_timeout;
		logic [MS_BITS-1:0] ret_timeout;
	} cfg_t;

	typedef struct packed {
		logic [1:0] status;
		logic       valve;
		logic [1:0] ext_ev;
		logic [1:0] ret_ev;
	} res_t;

endpackage

[sv/pcs_cfg_regs.sv]
// Configuration register file of the cylinder sequencer.
// Depends on pcs_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module pcs_cfg_regs import pcs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [MS_BITS-1:0]      cfg_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:      cfg_q.enable      <= cfg_data[0];
				REG_EXT_FITTED:  cfg_q.ext_fitted  <= cfg_data[0];
				REG_RET_FITTED:  cfg_q.ret_fitted  <= cfg_data[0];
				REG_EXT_SETTLE:  cfg_q.ext_settle  <= cfg_data;
				REG_RET_SETTLE:  cfg_q.ret_settle  <= cfg_data;
				REG_EXT_TIMEOUT: cfg_q.ext_timeout <= cfg_data;
				REG_RET_TIMEOUT: cfg_q.ret_timeout <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/pcs_core.sv]
// Sequencer state (phase, delay timer, valve level) and the per-request
// update logic that forms one result. Depends on pcs_pkg.
`timescale 1ns / 1ps

module pcs_core import pcs_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [2:0] cmd,
	input  logic       extend_sensor,
	input  logic       retract_sensor,
	input  cfg_t       cfg,
	output res_t       res
);

	localparam logic [TIMER_BITS-1:0] TMAX = '1;

	function automatic logic [TIMER_BITS-1:0] sat_load(input logic [MS_BITS-1:0] ms);
		logic [TIMER_BITS-1:0] r;
		if (TIMER_BITS >= MS_BITS) begin
			r = TIMER_BITS'(ms);
		end else if (ms > MS_BITS'(TMAX)) begin
			r = TMAX;
		end else begin
			r = TIMER_BITS'(ms);
		end
		return r;
	endfunction

	phase_t                phase_q, phase_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d;
	logic                  valve_q, valve_d;

	logic                  is_ext;
	logic                  fitted;
	logic                  sensor;
	logic [MS_BITS-1:0]    settle;
	logic [MS_BITS-1:0]    timeout;
	logic                  go_settle;
	logic                  wait_now;
	logic [TIMER_BITS-1:0] timer_eff;
	logic [1:0]            status;
	logic [1:0]            own_ev;

	assign is_ext  = (cmd == CMD_EXTEND);
	assign fitted  = is_ext ? cfg.ext_fitted  : cfg.ret_fitted;
	assign sensor  = is_ext ? extend_sensor   : retract_sensor;
	assign settle  = is_ext ? cfg.ext_settle  : cfg.ret_settle;
	assign timeout = is_ext ? cfg.ext_timeout : cfg.ret_timeout;

	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		valve_d   = valve_q;
		status    = ST_BUSY;
		own_ev    = EV_NONE;
		go_settle = 1'b0;
		wait_now  = 1'b0;
		timer_eff = timer_q;
		unique case (cmd)
			CMD_EXTEND, CMD_RETRACT: begin
				valve_d = is_ext;
				own_ev  = EV_CLEARED;
				if (phase_q == PH_IDLE) begin
					if (cfg.enable && fitted && !sensor) begin
						wait_now  = 1'b1;
						timer_eff = sat_load(timeout);
						timer_d   = timer_eff;
					end else begin
						go_settle = 1'b1;
					end
				end else if (phase_q == PH_WAIT) begin
					wait_now = 1'b1;
				end
				if (wait_now) begin
					if (sensor) begin
						go_settle = 1'b1;
					end else if (timer_eff == '0) begin
						phase_d = PH_IDLE;
						own_ev  = EV_RAISED;
						status  = ST_FAULT;
					end else begin
						phase_d = PH_WAIT;
						status  = ST_BUSY;
					end
				end
				if (go_settle) begin
					if (settle == '0) begin
						phase_d = PH_IDLE;
						status  = ST_DONE;
					end else begin
						timer_d = sat_load(settle);
						phase_d = PH_SETTLE;
						status  = ST_BUSY;
					end
				end else if (!wait_now) begin
					if (phase_q == PH_SETTLE && timer_q != '0) begin
						status = ST_BUSY;
					end else begin
						phase_d = PH_IDLE;
						status  = ST_DONE;
					end
				end
			end
			CMD_FORCE_EXTEND: begin
				valve_d = 1'b1;
				phase_d = PH_IDLE;
			end
			CMD_FORCE_RETRACT: begin
				valve_d = 1'b0;
				phase_d = PH_IDLE;
			end
			CMD_RESET: begin
				phase_d = PH_IDLE;
			end
			CMD_TICK: begin
				if (timer_q != '0) begin
					timer_d = timer_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			valve_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			valve_q <= valve_d;
		end
	end

	assign res.status = status;
	assign res.valve  = valve_d;
	assign res.ext_ev = is_ext ? own_ev : EV_NONE;
	assign res.ret_ev = (cmd == CMD_RETRACT) ? own_ev : EV_NONE;

endmodule

[sv/pcs_out_buf.sv]
// Result register with a skid stage, so a request is taken while an
// earlier result waits. Depends on pcs_pkg for the res_t struct.
`timescale 1ns / 1ps

module pcs_out_buf import pcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_res
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_res_q;
	res_t skid_res_q;
	logic pop;

	assign pop = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_res_q <= skid_res_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_res_q <= push_res;
			end else begin
				out_res_q <= push_res;
			end
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

[sv/pneumatic_cylinder_sequencer_top.sv]
// Top level of the pneumatic cylinder sequencer.
// Instantiates pcs_cfg_regs, pcs_core and pcs_out_buf; imports pcs_pkg.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_stall  cmd, extend_sensor, retract_sensor
//   output   out_valid/out_stall  status, valve_out, extend_alarm_event,
//                                 retract_alarm_event
//   config   cfg_we               cfg_index, cfg_data
//
// One request is taken per cycle while in_stall is low; its result is
// registered and shows on the output in the next cycle, or once the results
// ahead of it have been taken. The state update is a single combinational
// pass from the request and the state registers into the result register.
// A skid stage holds one more result, so in_stall rises only when two
// results are waiting. Reset clears all state and configuration at once.
`timescale 1ns / 1ps

module pneumatic_cylinder_sequencer_top import pcs_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [MS_BITS-1:0]      cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              cmd,
	input  logic                    extend_sensor,
	input  logic                    retract_sensor,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic                    valve_out,
	output logic [1:0]              extend_alarm_event,
	output logic [1:0]              retract_alarm_event
);

	cfg_t cfg;
	res_t core_res;
	res_t out_res;
	logic full;
	logic accept;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	pcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcs_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.cmd            (cmd),
		.extend_sensor  (extend_sensor),
		.retract_sensor (retract_sensor),
		.cfg            (cfg),
		.res            (core_res)
	);

	pcs_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_res  (core_res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign status              = out_res.status;
	assign valve_out           = out_res.valve;
	assign extend_alarm_event  = out_res.ext_ev;
	assign retract_alarm_event = out_res.ret_ev;

endmodule

[dv/pneumatic_cylinder_sequencer_top_tb.sv]
// Self-checking testbench for pneumatic_cylinder_sequencer_top: directed and random
// poll, force, reset and tick requests under changing register settings.
// Depends on pcs_pkg and the sequencer RTL; results are predicted by the class below.
`timescale 1ns / 1ps

module pneumatic_cylinder_sequencer_top_tb;
	import pcs_pkg::*;

	localparam int TMR_W          = TIMER_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_REQUESTS = 100;

	class cylinder_checker;
		cfg_t             cfg;
		phase_t           phase;
		logic [TMR_W-1:0] timer;
		logic             valve;
		res_t             awaited[$];
		int               errors;
		int               checked;

		function new();
			cfg     = '0;
			phase   = PH_IDLE;
			timer   = '0;
			valve   = 1'b0;
			errors  = 0;
			checked = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [MS_BITS-1:0] val);
			case (idx)
				REG_ENABLE:      cfg.enable = val[0];
				REG_EXT_FITTED:  cfg.ext_fitted = val[0];
				REG_RET_FITTED:  cfg.ret_fitted = val[0];
				REG_EXT_SETTLE:  cfg.ext_settle = val;
				REG_RET_SETTLE:  cfg.ret_settle = val;
				REG_EXT_TIMEOUT: cfg.ext_timeout = val;
				REG_RET_TIMEOUT: cfg.ret_timeout = val;
				default: ;
			endcase
		endfunction

		function void load_timer(logic [MS_BITS-1:0] ms);
			longint unsigned top;
			top = (64'd1 << TMR_W) - 1;
			timer = (ms > top) ? top[TMR_W-1:0] : ms;
		endfunction

		function logic [1:0] run_poll(logic lvl, logic fitted, logic sensor,
				logic [MS_BITS-1:0] settle, logic [MS_BITS-1:0] tmo,
				output logic [1:0] ev);
			logic to_settle;
			to_settle = 1'b0;
			valve = lvl;
			ev = EV_CLEARED;
			if (phase == PH_IDLE) begin
				if (!cfg.enable || !(fitted && !sensor)) begin
					to_settle = 1'b1;
				end else begin
					load_timer(tmo);
					phase = PH_WAIT;
				end
			end
			if (!to_settle && phase == PH_WAIT) begin
				if (sensor) begin
					to_settle = 1'b1;
				end else if (timer == 0) begin
					phase = PH_IDLE;
					ev = EV_RAISED;
					return ST_FAULT;
				end else begin
					return ST_BUSY;
				end
			end
			if (to_settle) begin
				if (settle == 0) begin
					phase = PH_IDLE;
					return ST_DONE;
				end
				load_timer(settle);
				phase = PH_SETTLE;
			end
			if (phase == PH_SETTLE) begin
				if (timer == 0) begin
					phase = PH_IDLE;
					return ST_DONE;
				end
				return ST_BUSY;
			end
			phase = PH_IDLE;
			return ST_DONE;
		endfunction

		function void note_request(logic [2:0] c, logic ext_s, logic ret_s);
			res_t       r;
			logic [1:0] ev;
			r.status = ST_BUSY;
			r.ext_ev = EV_NONE;
			r.ret_ev = EV_NONE;
			case (c)
				CMD_EXTEND: begin
					r.status = run_poll(1'b1, cfg.ext_fitted, ext_s, cfg.ext_settle,
						cfg.ext_timeout, ev);
					r.ext_ev = ev;
				end
				CMD_RETRACT: begin
					r.status = run_poll(1'b0, cfg.ret_fitted, ret_s, cfg.ret_settle,
						cfg.ret_timeout, ev);
					r.ret_ev = ev;
				end
				CMD_FORCE_EXTEND: begin
					valve = 1'b1;
					phase = PH_IDLE;
				end
				CMD_FORCE_RETRACT: begin
					valve = 1'b0;
					phase = PH_IDLE;
				end
				CMD_RESET: phase = PH_IDLE;
				CMD_TICK: if (timer != 0) timer = timer - 1'b1;
				default: ;
			endcase
			r.valve = valve;
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			checked++;
			if (awaited.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
			end else begin
				want = awaited.pop_front();
				compare_field("status", int'(want.status), int'(got.status));
				compare_field("valve_out", int'(want.valve), int'(got.valve));
				compare_field("extend_alarm_event", int'(want.ext_ev), int'(got.ext_ev));
				compare_field("retract_alarm_event", int'(want.ret_ev),
					int'(got.ret_ev));
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	reg_idx_t                cfg_index;
	logic [MS_BITS-1:0]      cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [2:0]              cmd;
	logic                    extend_sensor;
	logic                    retract_sensor;
	logic                    out_valid;
	logic                    out_stall;
	logic [1:0]              status;
	logic                    valve_out;
	logic [1:0]              extend_alarm_event;
	logic [1:0]              retract_alarm_event;

	cylinder_checker board;
	int  requests_sent;
	int  effective_sent;
	int  results_seen;
	int  settings_applied;
	int  hold_left;
	bit  held;
	int  quiet_cycles;
	logic quiet;

	assign quiet = (requests_sent >= 350 && requests_sent < 500);

	pneumatic_cylinder_sequencer_top uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.cmd                 (cmd),
		.extend_sensor       (extend_sensor),
		.retract_sensor      (retract_sensor),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.status              (status),
		.valve_out           (valve_out),
		.extend_alarm_event  (extend_alarm_event),
		.retract_alarm_event (retract_alarm_event)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (!held && results_seen >= 650) begin
			held = 1'b1;
			hold_left = 80;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (!quiet && $urandom_range(0, 99) < 7);
		end
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got.status = status;
			got.valve  = valve_out;
			got.ext_ev = extend_alarm_event;
			got.ret_ev = retract_alarm_event;
			board.check_result(got);
			results_seen++;
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Timeout: nothing moved for %0d cycles.", WATCHDOG_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic send_request(logic [2:0] c, logic ext_s, logic ret_s);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		cmd            <= c;
		extend_sensor  <= ext_s;
		retract_sensor <= ret_s;
		do @(posedge clk); while (in_stall);
		board.note_request(c, ext_s, ret_s);
		requests_sent++;
		if (c <= CMD_TICK)
			effective_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [MS_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, val);
	endtask

	task automatic program_settings(logic en, logic ext_fit, logic ret_fit,
			logic [MS_BITS-1:0] ext_settle, logic [MS_BITS-1:0] ret_settle,
			logic [MS_BITS-1:0] ext_tmo, logic [MS_BITS-1:0] ret_tmo);
		write_reg(REG_ENABLE, MS_BITS'(en));
		write_reg(REG_EXT_FITTED, MS_BITS'(ext_fit));
		write_reg(REG_RET_FITTED, MS_BITS'(ret_fit));
		write_reg(REG_EXT_SETTLE, ext_settle);
		write_reg(REG_RET_SETTLE, ret_settle);
		write_reg(REG_EXT_TIMEOUT, ext_tmo);
		write_reg(REG_RET_TIMEOUT, ret_tmo);
		settings_applied++;
	endtask

	function automatic logic [MS_BITS-1:0] pick_ms();
		int r;
		r = $urandom_range(0, 19);
		if (r < 3)
			return '0;
		else if (r == 19)
			return '1;
		return MS_BITS'($urandom_range(1, 6));
	endfunction

	task automatic drive_stroke();
		logic       retract_dir;
		logic       reached;
		logic [2:0] poll_cmd;
		logic [2:0] other_cmd;
		int         steps;
		int         r;
		retract_dir = coin();
		poll_cmd    = retract_dir ? CMD_RETRACT : CMD_EXTEND;
		other_cmd   = retract_dir ? CMD_EXTEND : CMD_RETRACT;
		reached     = ($urandom_range(0, 3) == 0);
		if (retract_dir)
			send_request(poll_cmd, coin(), reached);
		else
			send_request(poll_cmd, reached, coin());
		steps = $urandom_range(1, 14);
		repeat (steps) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				send_request(CMD_TICK, coin(), coin());
			end else if (r < 85) begin
				reached = reached | ($urandom_range(0, 3) == 0);
				if (retract_dir)
					send_request(poll_cmd, coin(), reached);
				else
					send_request(poll_cmd, reached, coin());
			end else if (r < 92) begin
				send_request(other_cmd, coin(), coin());
			end else begin
				send_request(3'($urandom_range(CMD_FORCE_EXTEND, CMD_RESET)),
					coin(), coin());
			end
		end
	endtask

	task automatic drive_noise();
		repeat ($urandom_range(1, 4))
			send_request(3'($urandom_range(0, 7)), coin(), coin());
	endtask

	initial begin
		int start;
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_ENABLE;
		cfg_data       = '0;
		in_valid       = 1'b0;
		cmd            = CMD_EXTEND;
		extend_sensor  = 1'b0;
		retract_sensor = 1'b0;
		out_stall      = 1'b0;
		hold_left      = 0;
		held           = 1'b0;
		requests_sent  = 0;
		effective_sent = 0;
		results_seen   = 0;
		settings_applied = 0;
		board = new();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: every poll is disabled and settles at once.
		send_request(CMD_EXTEND, 1'b0, 1'b0);
		send_request(CMD_RETRACT, 1'b0, 1'b0);
		send_request(CMD_FORCE_EXTEND, 1'b1, 1'b0);
		send_request(CMD_FORCE_RETRACT, 1'b0, 1'b1);
		send_request(CMD_RESET, 1'b0, 1'b0);
		send_request(CMD_TICK, 1'b1, 1'b1);
		send_request(3'd6, 1'b1, 1'b1);
		send_request(3'd7, 1'b0, 1'b0);
		drain();

		// Zero retract timeout faults at once; extend waits, settles and times out.
		program_settings(1'b1, 1'b1, 1'b1, 16'd2, 16'd0, 16'd2, 16'd0);
		send_request(CMD_RETRACT, 1'b1, 1'b0);
		send_request(CMD_EXTEND, 1'b0, 1'b0);
		send_request(CMD_TICK, 1'b0, 1'b0);
		send_request(CMD_RETRACT, 1'b0, 1'b1);
		send_request(CMD_EXTEND, 1'b0, 1'b1);
		send_request(CMD_TICK, 1'b0, 1'b0);
		send_request(CMD_TICK, 1'b0, 1'b0);
		send_request(CMD_EXTEND, 1'b0, 1'b0);
		send_request(CMD_EXTEND, 1'b1, 1'b0);
		send_request(CMD_TICK, 1'b1, 1'b0);
		send_request(CMD_TICK, 1'b1, 1'b0);
		send_request(CMD_EXTEND, 1'b1, 1'b0);
		send_request(CMD_EXTEND, 1'b0, 1'b0);
		drain();

		// Disabling while a sensor wait is open must not end the wait.
		write_reg(REG_ENABLE, '0);
		send_request(CMD_EXTEND, 1'b0, 1'b0);
		send_request(CMD_RESET, 1'b0, 1'b0);
		drain();

		program_settings(1'b1, 1'b1, 1'b1, '1, '1, '1, '1);
		send_request(CMD_EXTEND, 1'b0, 1'b0);
		send_request(CMD_TICK, 1'b0, 1'b0);
		send_request(CMD_EXTEND, 1'b1, 1'b0);
		send_request(CMD_RESET, 1'b0, 1'b0);
		drain();

		repeat (RANDOM_PHASES) begin
			program_settings($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
				$urandom_range(0, 3) != 0, pick_ms(), pick_ms(), pick_ms(), pick_ms());
			start = effective_sent;
			while (effective_sent - start < PHASE_REQUESTS) begin
				if ($urandom_range(0, 4) == 0)
					drive_noise();
				else
					drive_stroke();
			end
			drain();
		end

		drain();
		$display("Sent %0d requests under %0d register settings; %0d results checked.",
			requests_sent, settings_applied, results_seen);
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
